>>> rtl/sfrh_pkg.sv
package sfrh_pkg;

    // Default configuration
    localparam int MAX_STREAMS_DEF  = 64;
    localparam int WINDOW_TICKS_DEF = 60;

    // Field and counter widths
    localparam int SLOT_W   = 6;
    localparam int FRAMES_W = 32;
    localparam int RSUM_W   = 38;
    localparam int LIVE_W   = 7;
    localparam int WSUM_W   = 12;
    localparam int BKT_W    = 12;
    localparam int SECS_W   = 6;
    localparam int WCNT_W   = 8;
    localparam int NUM_BKT  = 5;

    // Rate bucket thresholds
    localparam logic [FRAMES_W-1:0] RATE_25 = 32'd25;
    localparam logic [FRAMES_W-1:0] RATE_20 = 32'd20;
    localparam logic [FRAMES_W-1:0] RATE_10 = 32'd10;
    localparam logic [FRAMES_W-1:0] RATE_5  = 32'd5;

    // Bucket codes
    localparam logic [2:0] BKT_25_UP    = 3'd0;
    localparam logic [2:0] BKT_20_24    = 3'd1;
    localparam logic [2:0] BKT_10_19    = 3'd2;
    localparam logic [2:0] BKT_5_9      = 3'd3;
    localparam logic [2:0] BKT_UNDER_5  = 3'd4;

    typedef struct packed {
        logic [SLOT_W-1:0]   stream_index;
        logic                stream_present;
        logic                connected;
        logic [FRAMES_W-1:0] painted_frames;
        logic [FRAMES_W-1:0] decoded_frames;
        logic                last_of_tick;
    } sfrh_report_t;

    typedef struct packed {
        logic [FRAMES_W-1:0] stream_fps;
        logic                tick_done;
        logic [RSUM_W-1:0]   aggregate_fps;
        logic [LIVE_W-1:0]   live_streams;
        logic [SECS_W-1:0]   seconds_remaining;
        logic                window_done;
        logic [BKT_W-1:0]    count_25_up;
        logic [BKT_W-1:0]    count_20_24;
        logic [BKT_W-1:0]    count_10_19;
        logic [BKT_W-1:0]    count_5_9;
        logic [BKT_W-1:0]    count_under_5;
        logic [LIVE_W-1:0]   avg_active_streams;
    } sfrh_result_t;

endpackage

>>> rtl/stream_frame_rate_histogram_unit.sv
// Stream frame-rate histogram.
//
// report channel: one stream report per transfer (slot, present, connected,
// painted and decoded frame counters, last_of_tick). result channel: exactly
// one result transfer per report, in report order.
//
// result_valid rises once a report has passed from the work stage register into
// the output register. A report can be taken every cycle while report_stall is
// low; throughput is one report per cycle when result_stall does not hold the
// output. The per-slot frame store has a single read port; it is read as the
// report is taken and written when the report leaves the work stage.
//
// When result_stall is high with a result waiting, the work stage holds its
// report and report_stall rises only if that stage is also occupied, so one
// further report is still taken while a result waits.
//
// Reset (rst_n low, asynchronous) clears all handshake state, the per-slot
// valid bits (stored counts then read as zero), the bucket counters and the
// tick and window accumulators. No clearing pass is needed.
module stream_frame_rate_histogram_unit #(
    parameter int MAX_STREAMS  = sfrh_pkg::MAX_STREAMS_DEF,
    parameter int WINDOW_TICKS = sfrh_pkg::WINDOW_TICKS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   report_valid,
    output logic                   report_stall,
    input  sfrh_pkg::sfrh_report_t report_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output sfrh_pkg::sfrh_result_t result_data
);
    import sfrh_pkg::*;

    // Only slots reachable by the 6-bit index need storage.
    localparam int MEM_DEPTH = (MAX_STREAMS < (1 << SLOT_W)) ? MAX_STREAMS : (1 << SLOT_W);
    localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W     = 9;

    // Rounded average: (2*sum + N) / (2*N) with N = WINDOW_TICKS, done as a
    // reciprocal multiply. 2^AVG_SHIFT >= max numerator * divisor keeps it exact.
    localparam int AVG_DIV   = 2 * WINDOW_TICKS;
    localparam int NUM_W     = 14;
    localparam int AVG_SHIFT = 24;
    localparam int RECIP_W   = 24;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV);

    localparam logic [RSUM_W-1:0] RSUM_MAX = '1;
    localparam logic [LIVE_W-1:0] LIVE_MAX = '1;
    localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
    localparam logic [BKT_W-1:0]  BKT_MAX  = '1;

    // Handshake
    logic report_accept;
    logic advance;

    // Work stage
    logic                s1_valid_reg;
    sfrh_report_t        s1_data_reg;
    logic [FRAMES_W-1:0] rd_frames_reg;
    logic                rd_hit_reg;

    // Per-slot frame store and its valid bits
    logic [FRAMES_W-1:0] frames_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] slot_valid_reg;

    // Window and tick state
    logic [BKT_W-1:0]  bucket_reg [NUM_BKT];
    logic [BKT_W-1:0]  bucket_next [NUM_BKT];
    logic [RSUM_W-1:0] rate_sum_reg, rate_sum_next;
    logic [LIVE_W-1:0] live_cnt_reg, live_cnt_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;

    // Output register
    logic         result_valid_reg;
    sfrh_result_t result_data_reg, result_data_next;

    // Work-stage datapath
    logic                in_range;
    logic [IDX_W-1:0]    s1_idx;
    logic [IDX_W-1:0]    rpt_idx;
    logic                wr_en;
    logic [FRAMES_W-1:0] wr_data;
    logic                live_item;
    logic [FRAMES_W-1:0] cur_frames;
    logic [FRAMES_W-1:0] prev_frames;
    logic [FRAMES_W-1:0] rate;
    logic [2:0]          bkt_sel;
    logic [BKT_W-1:0]    bucket_after [NUM_BKT];
    logic [RSUM_W:0]     rate_sum_wide;
    logic [RSUM_W-1:0]   rate_sum_after;
    logic [LIVE_W-1:0]   live_after;
    logic [WSUM_W:0]     wsum_wide;
    logic [WSUM_W-1:0]   wsum_after;
    logic [WCNT_W-1:0]   wcnt_inc;
    logic                window_close;
    logic [NUM_W-1:0]    avg_num;
    logic [PROD_W-1:0]   avg_prod;
    logic [WCNT_W-1:0]   secs_left;
    logic                fwd_hit;

    assign advance       = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign report_stall  = s1_valid_reg && !advance;
    assign report_accept = report_valid && !report_stall;

    assign s1_idx  = s1_data_reg.stream_index[IDX_W-1:0];
    assign rpt_idx = report_data.stream_index[IDX_W-1:0];

    // Back-to-back reports to the same slot: take the value being written.
    assign fwd_hit = advance && wr_en && (s1_idx == rpt_idx);

    always_comb
    begin
        in_range    = ({3'b000, s1_data_reg.stream_index} < CMP_W'(MAX_STREAMS));
        wr_en       = s1_data_reg.stream_present && in_range;
        live_item   = wr_en && s1_data_reg.connected;
        cur_frames  = (s1_data_reg.painted_frames != '0) ? s1_data_reg.painted_frames
                                                         : s1_data_reg.decoded_frames;
        prev_frames = rd_hit_reg ? rd_frames_reg : '0;
        wr_data     = s1_data_reg.connected ? cur_frames : s1_data_reg.painted_frames;

        // Counter went backwards: the current count is the delta.
        if (!live_item)
            rate = '0;
        else if (cur_frames >= prev_frames)
            rate = cur_frames - prev_frames;
        else
            rate = cur_frames;

        if (rate >= RATE_25)
            bkt_sel = BKT_25_UP;
        else if (rate >= RATE_20)
            bkt_sel = BKT_20_24;
        else if (rate >= RATE_10)
            bkt_sel = BKT_10_19;
        else if (rate >= RATE_5)
            bkt_sel = BKT_5_9;
        else
            bkt_sel = BKT_UNDER_5;

        for (int b = 0; b < NUM_BKT; b++)
        begin
            bucket_after[b] = bucket_reg[b];
            if (live_item && (bkt_sel == 3'(b)) && (bucket_reg[b] != BKT_MAX))
                bucket_after[b] = bucket_reg[b] + 1'b1;
        end

        rate_sum_wide  = {1'b0, rate_sum_reg} + {{(RSUM_W + 1 - FRAMES_W){1'b0}}, rate};
        rate_sum_after = rate_sum_wide[RSUM_W] ? RSUM_MAX : rate_sum_wide[RSUM_W-1:0];
        live_after     = (live_item && (live_cnt_reg != LIVE_MAX)) ? live_cnt_reg + 1'b1
                                                                   : live_cnt_reg;

        wsum_wide    = {1'b0, wsum_reg} + {{(WSUM_W + 1 - LIVE_W){1'b0}}, live_after};
        wsum_after   = wsum_wide[WSUM_W] ? WSUM_MAX : wsum_wide[WSUM_W-1:0];
        wcnt_inc     = wcnt_reg + 1'b1;
        window_close = s1_data_reg.last_of_tick && (wcnt_inc == WCNT_W'(WINDOW_TICKS));

        avg_num  = {1'b0, wsum_after, 1'b0} + NUM_W'(WINDOW_TICKS);
        avg_prod = {{RECIP_W{1'b0}}, avg_num} * {{NUM_W{1'b0}}, AVG_RECIP};

        // Next state
        if (s1_data_reg.last_of_tick)
        begin
            rate_sum_next = '0;
            live_cnt_next = '0;
            wsum_next     = window_close ? '0 : wsum_after;
            wcnt_next     = window_close ? '0 : wcnt_inc;
        end
        else
        begin
            rate_sum_next = rate_sum_after;
            live_cnt_next = live_after;
            wsum_next     = wsum_reg;
            wcnt_next     = wcnt_reg;
        end
        for (int b = 0; b < NUM_BKT; b++)
            bucket_next[b] = window_close ? '0 : bucket_after[b];

        secs_left = WCNT_W'(WINDOW_TICKS) - wcnt_next;

        // Result
        result_data_next            = '0;
        result_data_next.stream_fps = rate;
        if (s1_data_reg.last_of_tick)
        begin
            result_data_next.tick_done         = 1'b1;
            result_data_next.aggregate_fps     = rate_sum_after;
            result_data_next.live_streams      = live_after;
            result_data_next.seconds_remaining = secs_left[SECS_W-1:0];
        end
        if (window_close)
        begin
            result_data_next.window_done        = 1'b1;
            result_data_next.count_25_up        = bucket_after[BKT_25_UP];
            result_data_next.count_20_24        = bucket_after[BKT_20_24];
            result_data_next.count_10_19        = bucket_after[BKT_10_19];
            result_data_next.count_5_9          = bucket_after[BKT_5_9];
            result_data_next.count_under_5      = bucket_after[BKT_UNDER_5];
            result_data_next.avg_active_streams = avg_prod[AVG_SHIFT +: LIVE_W];
        end
    end

    // Frame store: written when a report leaves the work stage, read as one
    // is taken.
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
            frames_mem[s1_idx] <= wr_data;
        if (report_accept)
            rd_frames_reg <= fwd_hit ? wr_data : frames_mem[rpt_idx];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (report_accept)
            s1_data_reg <= report_data;
        if (advance)
            result_data_reg <= result_data_next;
    end

    // Control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            rd_hit_reg       <= 1'b0;
            slot_valid_reg   <= '0;
            rate_sum_reg     <= '0;
            live_cnt_reg     <= '0;
            wsum_reg         <= '0;
            wcnt_reg         <= '0;
            for (int b = 0; b < NUM_BKT; b++)
                bucket_reg[b] <= '0;
        end
        else
        begin
            if (report_accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_hit_reg   <= fwd_hit || slot_valid_reg[rpt_idx];
            end
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (advance)
            begin
                if (wr_en)
                    slot_valid_reg[s1_idx] <= 1'b1;
                rate_sum_reg <= rate_sum_next;
                live_cnt_reg <= live_cnt_next;
                wsum_reg     <= wsum_next;
                wcnt_reg     <= wcnt_next;
                for (int b = 0; b < NUM_BKT; b++)
                    bucket_reg[b] <= bucket_next[b];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule
